@@ sv/doorbell_press_limiter_controller_defines.svh @@
// assertion macros for the doorbell press limiter controller checker
`ifndef DOORBELL_PRESS_LIMITER_CONTROLLER_DEFINES_SVH
`define DOORBELL_PRESS_LIMITER_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked on every clock outside reset
`define DPLC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dplc assertion failed");

// next-cycle implication, checked on every clock outside reset
`define DPLC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dplc assertion failed");

`endif

@@ sv/dplc_pkg.sv @@
// shared types, codes and reset values for the doorbell press limiter controller
package dplc_pkg;

    localparam int MAX_EVENTS       = 4;
    localparam int EV_IDX_W         = $clog2(MAX_EVENTS);
    localparam int EV_CNT_W         = $clog2(MAX_EVENTS + 1);
    localparam int DPLC_QUEUE_DEPTH = 16;

    localparam logic [15:0] DEBOUNCE_RST       = 16'd30;
    localparam logic [31:0] RATE_WINDOW_RST    = 32'd30000;
    localparam logic [3:0]  PRESS_LIMIT_RST    = 4'd3;
    localparam logic [15:0] HOLD_RST           = 16'd2000;
    localparam logic [31:0] INTERCOM_LIMIT_RST = 32'd60000;
    localparam logic [31:0] IDLE_TIMEOUT_RST   = 32'd60000;
    localparam logic [7:0]  CHUNK_PERIOD_RST   = 8'd13;
    localparam logic [15:0] FRAMED_CHUNKS_RST  = 16'd3;

    typedef enum logic [2:0] {
        CFG_DEBOUNCE       = 3'd0,
        CFG_RATE_WINDOW    = 3'd1,
        CFG_PRESS_LIMIT    = 3'd2,
        CFG_HOLD           = 3'd3,
        CFG_INTERCOM_LIMIT = 3'd4,
        CFG_IDLE_TIMEOUT   = 3'd5,
        CFG_CHUNK_PERIOD   = 3'd6,
        CFG_FRAMED_CHUNKS  = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MODE_ACTIVE   = 3'b001,
        MODE_INTERCOM = 3'b010,
        MODE_SLEEP    = 3'b100
    } mode_t;

    typedef enum logic [2:0] {
        EV_BELL  = 3'd0,
        EV_BEGIN = 3'd1,
        EV_CHUNK = 3'd2,
        EV_END   = 3'd3,
        EV_SLEEP = 3'd4,
        EV_WAKE  = 3'd5
    } event_kind_t;

    typedef struct packed {
        logic [15:0] debounce_time;
        logic [31:0] rate_window_ms;
        logic [3:0]  press_limit;
        logic [15:0] hold_ms;
        logic [31:0] intercom_limit_ms;
        logic [31:0] idle_timeout_ms;
        logic [7:0]  chunk_period_ms;
        logic [15:0] framed_chunks;
    } cfg_t;

    typedef struct packed {
        event_kind_t kind;
        logic [3:0]  presses;
        logic        lockout;
        logic        sound_on;
        logic [31:0] bell_seq;
        logic [15:0] voice_seq;
        logic        framed;
        logic        cause;
        logic        last;
    } event_t;

    typedef struct packed {
        logic [EV_CNT_W-1:0]          count;
        event_t [MAX_EVENTS-1:0]      slot;
    } ev_batch_t;

endpackage

@@ sv/dplc_cfg.sv @@
// configuration register file with write decode
module dplc_cfg
    import dplc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_DEBOUNCE:       cfg_next.debounce_time     = cfg_data[15:0];
                CFG_RATE_WINDOW:    cfg_next.rate_window_ms    = cfg_data;
                CFG_PRESS_LIMIT:    cfg_next.press_limit       = cfg_data[3:0];
                CFG_HOLD:           cfg_next.hold_ms           = cfg_data[15:0];
                CFG_INTERCOM_LIMIT: cfg_next.intercom_limit_ms = cfg_data;
                CFG_IDLE_TIMEOUT:   cfg_next.idle_timeout_ms   = cfg_data;
                CFG_CHUNK_PERIOD:   cfg_next.chunk_period_ms   = cfg_data[7:0];
                CFG_FRAMED_CHUNKS:  cfg_next.framed_chunks     = cfg_data[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time     <= DEBOUNCE_RST;
            cfg_reg.rate_window_ms    <= RATE_WINDOW_RST;
            cfg_reg.press_limit       <= PRESS_LIMIT_RST;
            cfg_reg.hold_ms           <= HOLD_RST;
            cfg_reg.intercom_limit_ms <= INTERCOM_LIMIT_RST;
            cfg_reg.idle_timeout_ms   <= IDLE_TIMEOUT_RST;
            cfg_reg.chunk_period_ms   <= CHUNK_PERIOD_RST;
            cfg_reg.framed_chunks     <= FRAMED_CHUNKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/dplc_core.sv @@
// tick register, controller state and per-tick event generation
module dplc_core
    import dplc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  logic      bell_button,
    input  logic      talk_button,
    input  cfg_t      cfg,
    output ev_batch_t batch
);

    logic        tick_valid_reg;
    logic        bell_in_reg;
    logic        talk_in_reg;

    logic [31:0] time_reg,       time_next;
    mode_t       mode_reg,       mode_next;
    logic [3:0]  press_reg,      press_next;
    logic        locked_reg,     locked_next;
    logic [31:0] window_reg,     window_next;
    logic [31:0] activity_reg,   activity_next;
    logic [31:0] session_reg,    session_next;
    logic [31:0] bell_cnt_reg,   bell_cnt_next;
    logic [15:0] chunk_cnt_reg,  chunk_cnt_next;
    logic [31:0] next_chunk_reg, next_chunk_next;
    logic [31:0] edge_reg,       edge_next;
    logic        bell_seen_reg,  bell_seen_next;
    logic [31:0] hold_reg,       hold_next;
    logic        talk_held_reg,  talk_held_next;

    ev_batch_t           batch_next;
    logic                press_req;
    logic [31:0]         chunk_gap;
    logic [7:0]          period;
    logic [EV_IDX_W-1:0] last_idx;

    function automatic event_t make_event(
        input event_kind_t kind,
        input logic [3:0]  presses,
        input logic        lockout,
        input logic        sound_on,
        input logic [31:0] bell_seq,
        input logic [15:0] voice_seq,
        input logic        framed,
        input logic        cause
    );
        event_t e;
        e.kind      = kind;
        e.presses   = presses;
        e.lockout   = lockout;
        e.sound_on  = sound_on;
        e.bell_seq  = bell_seq;
        e.voice_seq = voice_seq;
        e.framed    = framed;
        e.cause     = cause;
        e.last      = 1'b0;
        return e;
    endfunction

    function automatic ev_batch_t add_event(input ev_batch_t b, input event_t e);
        ev_batch_t r;
        r = b;
        if (r.count < EV_CNT_W'(MAX_EVENTS))
        begin
            r.slot[EV_IDX_W'(r.count)] = e;
            r.count = r.count + EV_CNT_W'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        time_next       = time_reg;
        mode_next       = mode_reg;
        press_next      = press_reg;
        locked_next     = locked_reg;
        window_next     = window_reg;
        activity_next   = activity_reg;
        session_next    = session_reg;
        bell_cnt_next   = bell_cnt_reg;
        chunk_cnt_next  = chunk_cnt_reg;
        next_chunk_next = next_chunk_reg;
        edge_next       = edge_reg;
        bell_seen_next  = bell_seen_reg;
        hold_next       = hold_reg;
        talk_held_next  = talk_held_reg;
        batch_next      = '0;
        press_req       = 1'b0;
        chunk_gap       = time_reg - next_chunk_reg;
        period          = (cfg.chunk_period_ms == 8'd0) ? 8'd1 : cfg.chunk_period_ms;
        last_idx        = '0;

        if (tick_valid_reg)
        begin
            time_next = time_reg + 32'd1;

            // wake, or debounced bell edge
            if (mode_reg == MODE_SLEEP)
            begin
                if (bell_in_reg || talk_in_reg)
                begin
                    bell_seen_next = bell_in_reg;
                    edge_next      = time_reg;
                    talk_held_next = talk_in_reg;
                    hold_next      = time_reg;
                    mode_next      = MODE_ACTIVE;
                    press_next     = 4'd0;
                    locked_next    = 1'b0;
                    window_next    = time_reg;
                    activity_next  = time_reg;
                    batch_next = add_event(batch_next, make_event(EV_WAKE, press_next,
                        locked_next, 1'b0, 32'd0, 16'd0, 1'b0, 1'b0));
                    press_req = 1'b1;
                end
            end
            else if ((bell_in_reg != bell_seen_reg)
                     && ((time_reg - edge_reg) > 32'(cfg.debounce_time)))
            begin
                edge_next      = time_reg;
                bell_seen_next = bell_in_reg;
                press_req      = bell_in_reg && (mode_reg == MODE_ACTIVE);
            end

            // press counting inside the rate window
            if (press_req)
            begin
                activity_next = time_reg;
                if ((time_reg - window_next) > cfg.rate_window_ms)
                begin
                    press_next  = 4'd0;
                    locked_next = 1'b0;
                    window_next = time_reg;
                end
                if (press_next < cfg.press_limit)
                    press_next = press_next + 4'd1;
                if (press_next >= cfg.press_limit)
                    locked_next = 1'b1;
                bell_cnt_next = bell_cnt_reg + 32'd1;
                batch_next = add_event(batch_next, make_event(EV_BELL, press_next,
                    locked_next, !locked_next, bell_cnt_next, 16'd0, 1'b0, 1'b0));
            end

            if (mode_reg != MODE_SLEEP)
            begin
                // talk hold tracking and session open
                if (talk_in_reg && !talk_held_next)
                begin
                    talk_held_next = 1'b1;
                    hold_next      = time_reg;
                end
                if (!talk_in_reg && talk_held_next)
                    talk_held_next = 1'b0;
                if (talk_held_next && (mode_next == MODE_ACTIVE)
                    && ((time_reg - hold_next) >= 32'(cfg.hold_ms)))
                begin
                    mode_next       = MODE_INTERCOM;
                    session_next    = time_reg;
                    activity_next   = time_reg;
                    chunk_cnt_next  = 16'd0;
                    next_chunk_next = time_reg;
                    batch_next = add_event(batch_next, make_event(EV_BEGIN, press_next,
                        locked_next, 1'b0, 32'd0, 16'd0, 1'b0, 1'b0));
                end

                // chunk pacing and session end
                if (mode_next == MODE_INTERCOM)
                begin
                    activity_next = time_reg;
                    chunk_gap     = time_reg - next_chunk_next;
                    if (!chunk_gap[31])
                    begin
                        chunk_cnt_next  = chunk_cnt_next + 16'd1;
                        batch_next = add_event(batch_next, make_event(EV_CHUNK, press_next,
                            locked_next, 1'b0, 32'd0, chunk_cnt_next,
                            chunk_cnt_next <= cfg.framed_chunks, 1'b0));
                        next_chunk_next = next_chunk_next + 32'(period);
                    end
                    if (!talk_in_reg
                        || ((time_reg - session_next) > cfg.intercom_limit_ms))
                    begin
                        batch_next = add_event(batch_next, make_event(EV_END, press_next,
                            locked_next, 1'b0, 32'd0, chunk_cnt_next, 1'b0, talk_in_reg));
                        mode_next   = MODE_ACTIVE;
                        window_next = time_reg;
                        press_next  = 4'd0;
                        locked_next = 1'b0;
                    end
                end

                // idle timeout
                if ((mode_next == MODE_ACTIVE)
                    && ((time_reg - activity_next) > cfg.idle_timeout_ms))
                begin
                    mode_next = MODE_SLEEP;
                    batch_next = add_event(batch_next, make_event(EV_SLEEP, press_next,
                        locked_next, 1'b0, 32'd0, 16'd0, 1'b0, 1'b0));
                end
            end

            if (batch_next.count != '0)
            begin
                last_idx = EV_IDX_W'(batch_next.count - EV_CNT_W'(1));
                batch_next.slot[last_idx].last = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
            time_reg       <= '0;
            mode_reg       <= MODE_ACTIVE;
            press_reg      <= '0;
            locked_reg     <= 1'b0;
            window_reg     <= '0;
            activity_reg   <= '0;
            session_reg    <= '0;
            bell_cnt_reg   <= '0;
            chunk_cnt_reg  <= '0;
            next_chunk_reg <= '0;
            edge_reg       <= '0;
            bell_seen_reg  <= 1'b0;
            hold_reg       <= '0;
            talk_held_reg  <= 1'b0;
        end
        else
        begin
            tick_valid_reg <= accept;
            time_reg       <= time_next;
            mode_reg       <= mode_next;
            press_reg      <= press_next;
            locked_reg     <= locked_next;
            window_reg     <= window_next;
            activity_reg   <= activity_next;
            session_reg    <= session_next;
            bell_cnt_reg   <= bell_cnt_next;
            chunk_cnt_reg  <= chunk_cnt_next;
            next_chunk_reg <= next_chunk_next;
            edge_reg       <= edge_next;
            bell_seen_reg  <= bell_seen_next;
            hold_reg       <= hold_next;
            talk_held_reg  <= talk_held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bell_in_reg <= bell_button;
            talk_in_reg <= talk_button;
        end
    end

    assign batch = batch_next;

endmodule

@@ sv/dplc_evq.sv @@
// event queue taking up to four events per cycle and releasing one while out_stall is low
module dplc_evq
    import dplc_pkg::*;
#(
    parameter int QUEUE_DEPTH = DPLC_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ev_batch_t batch,
    input  logic      out_stall,
    output logic      out_valid,
    output event_t    head,
    output logic      room
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    event_t          mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign head      = mem_reg[rd_ptr_reg];
    // one tick in the input register and one arriving: two batches of headroom
    assign room      = (count_reg <= CW'(QUEUE_DEPTH - 2 * MAX_EVENTS));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(batch.count);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + CW'(batch.count) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_EVENTS; i++)
        begin
            if (EV_CNT_W'(i) < batch.count)
                mem_reg[wr_ptr_reg + AW'(i)] <= batch.slot[i];
        end
    end

endmodule

@@ sv/doorbell_press_limiter_controller.sv @@
// Doorbell press limiter and push-to-talk controller, top level. Each request
// on the input channel is one millisecond tick carrying the bell and talk
// button levels; it produces zero to four events, delivered one per request
// on the output channel in order, the final one of a tick flagged by
// last_event. A tick is registered on acceptance and its events are written
// into the event queue on the next clock. A new tick is taken every cycle
// while the event queue holds no more than QUEUE_DEPTH - 8 events; the
// sustained rate, while out_stall is low, is one tick per cycle for ticks with
// at most one event, and otherwise the output port, at one event per cycle,
// sets the pace. Configuration writes take effect on the next clock.
module doorbell_press_limiter_controller
    import dplc_pkg::*;
#(
    parameter int QUEUE_DEPTH = DPLC_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        bell_button,
    input  logic        talk_button,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [3:0]  presses,
    output logic        lockout,
    output logic        sound_on,
    output logic [31:0] bell_sequence,
    output logic [15:0] voice_sequence,
    output logic        chunk_framed,
    output logic        end_cause,
    output logic        last_event
);

    cfg_t      cfg;
    ev_batch_t batch;
    event_t    head;
    logic      room;
    logic      accept;

    assign in_stall = !room;
    assign accept   = in_valid && room;

    dplc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dplc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .bell_button (bell_button),
        .talk_button (talk_button),
        .cfg         (cfg),
        .batch       (batch)
    );

    dplc_evq #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_evq (
        .clk       (clk),
        .rst_n     (rst_n),
        .batch     (batch),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .head      (head),
        .room      (room)
    );

    assign event_kind     = head.kind;
    assign presses        = head.presses;
    assign lockout        = head.lockout;
    assign sound_on       = head.sound_on;
    assign bell_sequence  = head.bell_seq;
    assign voice_sequence = head.voice_seq;
    assign chunk_framed   = head.framed;
    assign end_cause      = head.cause;
    assign last_event     = head.last;

endmodule

@@ sv/dplc_checker.sv @@
// port-level checker for the doorbell press limiter controller, with its bind
`include "doorbell_press_limiter_controller_defines.svh"

module dplc_checker
    import dplc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        bell_button,
    input logic        talk_button,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  event_kind,
    input logic [3:0]  presses,
    input logic        lockout,
    input logic        sound_on,
    input logic [31:0] bell_sequence,
    input logic [15:0] voice_sequence,
    input logic        chunk_framed,
    input logic        end_cause,
    input logic        last_event
);

    logic        bell_shown;
    logic        non_bell;
    logic        non_voice;
    logic [1:0]  buttons;
    logic [59:0] shown_event;

    assign bell_shown  = out_valid && (event_kind == EV_BELL);
    assign non_bell    = out_valid && (event_kind != EV_BELL);
    assign non_voice   = out_valid && (event_kind != EV_CHUNK) && (event_kind != EV_END);
    assign buttons     = {bell_button, talk_button};
    assign shown_event = {event_kind, presses, lockout, sound_on, bell_sequence,
                          voice_sequence, chunk_framed, end_cause, last_event};

    // chime plays exactly when a bell is not locked out
    `DPLC_ASSERT_IMPLY(a_bell_sound, bell_shown, sound_on == !lockout)

    // only bell events carry a chime or a bell number
    `DPLC_ASSERT_IMPLY(a_nonbell_quiet, non_bell, !sound_on && bell_sequence == 32'd0)

    // framing and end reason belong to their own event kinds
    `DPLC_ASSERT_IMPLY(a_voice_fields, non_voice, !chunk_framed && !end_cause)

    // a stalled request holds
    `DPLC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(shown_event))

    // a stalled tick request holds
    `DPLC_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(buttons))

endmodule

bind doorbell_press_limiter_controller dplc_checker u_dplc_checker (.*);
